FILE: rtl/tagged_channel_byte_mailbox_defines.svh
// ----------------------------------------------------------------------------
// Tagged channel byte mailbox: assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef TAGGED_CHANNEL_BYTE_MAILBOX_DEFINES_SVH
`define TAGGED_CHANNEL_BYTE_MAILBOX_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define TCBM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked during reset as well.
`define TCBM_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tcbm_pkg.sv
// ----------------------------------------------------------------------------
// Tagged channel byte mailbox package
// Command, response and queue types shared by the mailbox modules.
// ----------------------------------------------------------------------------
package tcbm_pkg;

  localparam int ID_W   = 31;
  localparam int GEN_W  = 25;
  localparam int SLOT_W = 5;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2,
    OP_CLOSE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BAD    = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_FULL   = 3'd3,
    ST_EOF    = 3'd4,
    ST_NOFREE = 3'd5
  } status_t;

  typedef struct packed {
    op_t             op;
    logic [ID_W-1:0] endpoint_id;
    logic [7:0]      data_byte;
    logic            transfer_last;
  } cmd_t;

  typedef struct packed {
    status_t         status;
    logic [7:0]      read_byte;
    logic [ID_W-1:0] new_id;
    logic            last;
  } rsp_t;

  // Decoded command as it waits between front and back.
  typedef struct packed {
    op_t               op;
    logic [GEN_W-1:0]  gen;
    logic [SLOT_W-1:0] slot;
    logic              slot_ok;
    logic              end_sel;
    logic [7:0]        data_byte;
    logic              last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef enum logic {
    BK_EXEC = 1'b0,
    BK_RESP = 1'b1
  } back_state_t;

endpackage

FILE: rtl/tcbm_ram.sv
// ----------------------------------------------------------------------------
// Tagged channel byte mailbox: single-port RAM
// One address per cycle, optional write plus read, registered read data.
// ----------------------------------------------------------------------------
module tcbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/tcbm_front.sv
// ----------------------------------------------------------------------------
// Tagged channel byte mailbox: front end
// Accept commands, split the endpoint id and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module tcbm_front #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tcbm_pkg::cmd_t    cmd,
  output tcbm_pkg::q_head_t head,
  input  logic              pop
);
  import tcbm_pkg::*;

  localparam logic [SLOT_W:0] NC_L = (SLOT_W + 1)'(NUM_CHANNELS);

  item_t      entry [2];
  item_t      item_in;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign busy = (count == 2'd2);
  assign push = start && !busy;

  always_comb begin
    item_in.op        = cmd.op;
    item_in.gen       = cmd.endpoint_id[ID_W-1:SLOT_W+1];
    item_in.slot      = cmd.endpoint_id[SLOT_W:1];
    item_in.slot_ok   = ({1'b0, cmd.endpoint_id[SLOT_W:1]} < NC_L);
    item_in.end_sel   = cmd.endpoint_id[0];
    item_in.data_byte = cmd.data_byte;
    item_in.last      = cmd.transfer_last;
  end

  assign head.valid = (count != 2'd0);
  assign head.item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/tcbm_back.sv
// ----------------------------------------------------------------------------
// Tagged channel byte mailbox: back end
// Check ids, update slot and FIFO pointers, access the byte store, respond.
// ----------------------------------------------------------------------------
module tcbm_back #(
  parameter int NUM_CHANNELS = 8,
  parameter int FIFO_DEPTH   = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  tcbm_pkg::q_head_t head,
  output logic              pop,
  output logic              done,
  output tcbm_pkg::rsp_t    result
);
  import tcbm_pkg::*;

  localparam int SW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int AW        = $clog2(FIFO_DEPTH);
  localparam int LW        = $clog2(FIFO_DEPTH + 1);
  localparam int SUMW      = LW + 1;
  localparam int MAW       = SW + 1 + AW;
  localparam int MEM_DEPTH = 2 ** MAW;

  localparam logic [LW-1:0]   LEVEL_FULL = LW'(FIFO_DEPTH);
  localparam logic [SUMW-1:0] DEPTH_S    = SUMW'(FIFO_DEPTH);
  localparam logic [AW-1:0]   HEAD_LAST  = AW'(FIFO_DEPTH - 1);

  back_state_t state, state_next;

  logic [NUM_CHANNELS-1:0] slot_busy;
  logic [GEN_W-1:0]        slot_gen   [NUM_CHANNELS];
  logic [1:0]              end_closed [NUM_CHANNELS];
  logic [AW-1:0]           fifo_head  [NUM_CHANNELS][2];
  logic [LW-1:0]           fifo_level [NUM_CHANNELS][2];

  logic [SW-1:0]   free_idx;
  logic            free_ok;
  logic [SW-1:0]   sidx;
  logic            self_e;
  logic            peer_e;
  logic            id_ok;
  logic            fire;
  logic            upd;
  logic            busy_nx;
  logic [GEN_W-1:0] gen_nx;
  logic [1:0]      closed_nx;
  logic [AW-1:0]   head_nx  [2];
  logic [LW-1:0]   level_nx [2];
  logic [SUMW-1:0] tail_sum;
  logic [SUMW-1:0] tail;
  status_t         status_d;
  logic [ID_W-1:0] nid_d;
  logic            mem_we;
  logic            mem_rd;
  logic [MAW-1:0]  mem_addr;
  logic [7:0]      mem_rdata;

  status_t         rsp_status;
  logic [ID_W-1:0] rsp_nid;
  logic            rsp_last;
  logic            rsp_rd;

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    free_ok  = 1'b0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (!slot_busy[i]) begin
        free_idx = SW'(i);
        free_ok  = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    fire       = 1'b0;
    done       = 1'b0;
    sidx       = (head.item.op == OP_CREATE) ? free_idx : head.item.slot[SW-1:0];
    self_e     = head.item.end_sel;
    peer_e     = ~head.item.end_sel;
    id_ok      = head.item.slot_ok && slot_busy[sidx] && (slot_gen[sidx] == head.item.gen);
    upd        = 1'b0;
    busy_nx    = slot_busy[sidx];
    gen_nx     = slot_gen[sidx];
    closed_nx  = end_closed[sidx];
    head_nx[0] = fifo_head[sidx][0];
    head_nx[1] = fifo_head[sidx][1];
    level_nx[0] = fifo_level[sidx][0];
    level_nx[1] = fifo_level[sidx][1];
    tail_sum   = SUMW'(fifo_head[sidx][peer_e]) + SUMW'(fifo_level[sidx][peer_e]);
    tail       = (tail_sum >= DEPTH_S) ? (tail_sum - DEPTH_S) : tail_sum;
    status_d   = ST_OK;
    nid_d      = '0;
    mem_we     = 1'b0;
    mem_rd     = 1'b0;
    mem_addr   = {sidx, self_e, fifo_head[sidx][self_e]};

    unique case (head.item.op)
      OP_CREATE: begin
        if (!free_ok) begin
          status_d = ST_NOFREE;
        end else begin
          upd         = 1'b1;
          busy_nx     = 1'b1;
          gen_nx      = slot_gen[sidx] + GEN_W'(1);
          closed_nx   = 2'b00;
          head_nx[0]  = '0;
          head_nx[1]  = '0;
          level_nx[0] = '0;
          level_nx[1] = '0;
          nid_d       = {gen_nx, SLOT_W'(free_idx), 1'b0};
        end
      end
      OP_WRITE: begin
        if (!id_ok || end_closed[sidx][self_e] || end_closed[sidx][peer_e]) begin
          status_d = ST_BAD;
        end else if (fifo_level[sidx][peer_e] == LEVEL_FULL) begin
          status_d = ST_FULL;
        end else begin
          upd              = 1'b1;
          mem_we           = 1'b1;
          mem_addr         = {sidx, peer_e, tail[AW-1:0]};
          level_nx[peer_e] = fifo_level[sidx][peer_e] + LW'(1);
        end
      end
      OP_READ: begin
        if (!id_ok || end_closed[sidx][self_e]) begin
          status_d = ST_BAD;
        end else if (fifo_level[sidx][self_e] == '0) begin
          status_d = end_closed[sidx][peer_e] ? ST_EOF : ST_EMPTY;
        end else begin
          upd             = 1'b1;
          mem_rd          = 1'b1;
          head_nx[self_e] = (fifo_head[sidx][self_e] == HEAD_LAST) ? '0
                          : fifo_head[sidx][self_e] + AW'(1);
          level_nx[self_e] = fifo_level[sidx][self_e] - LW'(1);
        end
      end
      OP_CLOSE: begin
        if (id_ok) begin
          upd               = 1'b1;
          closed_nx[self_e] = 1'b1;
          if (end_closed[sidx][peer_e]) begin
            closed_nx   = 2'b00;
            head_nx[0]  = '0;
            head_nx[1]  = '0;
            level_nx[0] = '0;
            level_nx[1] = '0;
            busy_nx     = 1'b0;
          end
        end
      end
      default: ;
    endcase

    unique case (state)
      BK_EXEC: begin
        if (head.valid) begin
          fire       = 1'b1;
          state_next = BK_RESP;
        end
      end
      BK_RESP: begin
        done       = 1'b1;
        state_next = BK_EXEC;
      end
      default: state_next = BK_EXEC;
    endcase
  end

  assign pop = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_EXEC;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_busy <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        slot_gen[i]      <= '0;
        end_closed[i]    <= 2'b00;
        fifo_head[i][0]  <= '0;
        fifo_head[i][1]  <= '0;
        fifo_level[i][0] <= '0;
        fifo_level[i][1] <= '0;
      end
    end else if (fire && upd) begin
      slot_busy[sidx]     <= busy_nx;
      slot_gen[sidx]      <= gen_nx;
      end_closed[sidx]    <= closed_nx;
      fifo_head[sidx][0]  <= head_nx[0];
      fifo_head[sidx][1]  <= head_nx[1];
      fifo_level[sidx][0] <= level_nx[0];
      fifo_level[sidx][1] <= level_nx[1];
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_status <= status_d;
      rsp_nid    <= nid_d;
      rsp_last   <= head.item.last;
      rsp_rd     <= mem_rd;
    end
  end

  tcbm_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (fire && mem_we),
    .addr  (mem_addr),
    .wdata (head.item.data_byte),
    .rdata (mem_rdata)
  );

  always_comb begin
    result.status    = rsp_status;
    result.read_byte = rsp_rd ? mem_rdata : 8'd0;
    result.new_id    = rsp_nid;
    result.last      = rsp_last;
  end

endmodule

FILE: rtl/tagged_channel_byte_mailbox.sv
// ----------------------------------------------------------------------------
// Tagged channel byte mailbox
// Byte channels with generation-tagged endpoint ids over a shared byte store.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and raise start; the transaction is taken at a
//   rising edge where start is high and busy is low. cmd.op selects create,
//   write, read or close; cmd.endpoint_id carries generation, slot and end.
//   Response channel: done is high for exactly one cycle per command, with
//   result valid in that cycle. Responses come back in command order.
//   A command taken while the back end is free is written into a queue entry,
//   executed from the queue head in the back end's exec state and answered
//   with done in its response state. The back end takes no new command
//   until the last is answered: exec does the pointer update and byte-store
//   access, response presents the registered read data of the store RAM.
//   The front end holds up to two decoded commands; busy rises when both
//   queue entries are taken.
//   Reset (synchronous, active high) frees every slot, zeroes generations,
//   end flags and FIFO pointers, and empties the command queue. The byte
//   store is not cleared; the FIFO pointers keep reads on written bytes.
//   The receiver cannot stall: each response is presented once and dropped.
// ----------------------------------------------------------------------------
module tagged_channel_byte_mailbox #(
  parameter int NUM_CHANNELS = 8,
  parameter int FIFO_DEPTH   = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  tcbm_pkg::cmd_t cmd,
  output logic           done,
  output tcbm_pkg::rsp_t result
);
  import tcbm_pkg::*;

  // Head of the command queue, seen by the back end.
  q_head_t q_head;
  logic    q_pop;

  // Decode and buffer incoming transactions.
  tcbm_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .head  (q_head),
    .pop   (q_pop)
  );

  // Execute one transaction at a time and emit its response.
  tcbm_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .FIFO_DEPTH   (FIFO_DEPTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (q_head),
    .pop    (q_pop),
    .done   (done),
    .result (result)
  );

endmodule

FILE: rtl/tcbm_checker.sv
// ----------------------------------------------------------------------------
// Tagged channel byte mailbox: port checker
// Properties on the response channel and busy, bound to the top level.
// ----------------------------------------------------------------------------
`include "tagged_channel_byte_mailbox_defines.svh"

module tcbm_port_checker (
  input logic           clk,
  input logic           rst,
  input logic           busy,
  input logic           done,
  input tcbm_pkg::rsp_t result
);
  import tcbm_pkg::*;

  `TCBM_ASSERT_NEXT(a_rst_quiet, clk, rst, !busy && !done, "activity right after reset")
  `TCBM_ASSERT_NEXT(a_done_gap, clk, done, !done, "responses in adjacent cycles")
  `TCBM_ASSERT_IMPL(a_status_range, clk, rst, done, result.status <= ST_NOFREE, "bad status")
  `TCBM_ASSERT_IMPL(a_fail_clean, clk, rst, done && result.status != ST_OK, result.new_id == '0 && result.read_byte == '0, "payload on failed transaction")
  `TCBM_ASSERT_IMPL(a_id_even, clk, rst, done, !result.new_id[0], "new id names second end")

endmodule

bind tagged_channel_byte_mailbox tcbm_port_checker u_tcbm_checker (.*);
